// ===== hdl/bbla_pkg.sv =====
// ----------------------------------------------------------------------------
// bbla_pkg
// Shared types and constants of the box blur line averager.
// ----------------------------------------------------------------------------
package bbla_pkg;

    // Width of the radius register and its value after reset
    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] RADIUS_RESET = 4'd2;

    // Front sequencer: take a sample, add it to the window, send requests
    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_ADD,
        FRONT_EMIT
    } front_state_t;

    // Back divider: wait for a request, shift out quotient bits, hand over
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_HOLD
    } div_state_t;

endpackage

// ===== hdl/bbla_ram.sv =====
// ----------------------------------------------------------------------------
// bbla_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bbla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 31,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bbla_front.sv =====
// ----------------------------------------------------------------------------
// bbla_front
// Takes samples, keeps the window store and running sum, and sends one
// divide request (window sum, sample count, last flag) per averaged sample.
// ----------------------------------------------------------------------------
module bbla_front import bbla_pkg::*; #(
    parameter int MAX_RADIUS  = 15,
    parameter int SAMPLE_BITS = 16,
    localparam int DEPTH  = 2 * MAX_RADIUS + 1,
    localparam int CNT_W  = $clog2(DEPTH + 2),
    localparam int SUM_W  = SAMPLE_BITS + $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] sample_value,
    input  logic                          line_end,
    input  logic                          q_full,
    output logic                          q_push,
    output logic signed [SUM_W-1:0]       q_sum,
    output logic [CNT_W-1:0]              q_count,
    output logic                          q_done
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RAD_W  = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int OWD_W  = $clog2(MAX_RADIUS + 2);

    front_state_t state_reg, state_next;

    logic [CFG_W-1:0]              radius_cfg_reg;
    logic [RAD_W-1:0]              line_radius_reg, line_radius_next;
    logic                          in_line_reg, in_line_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                          last_reg, last_next;
    logic [ADDR_W-1:0]             wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]             tail_reg, tail_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic [OWD_W-1:0]              owed_reg, owed_next;
    logic [RAD_W-1:0]              left_reg, left_next;

    logic                          accept;
    logic                          ram_we;
    logic                          ram_re;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SAMPLE_BITS-1:0] tail_sample;
    logic [RAD_W-1:0]              radius_sat;
    logic [CNT_W-1:0]              win_count;
    logic                          drop;
    logic signed [SUM_W-1:0]       sum_out;
    logic                          flush_more;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        ptr_inc = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // radius register, clipped to the largest supported radius
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_cfg_reg <= RADIUS_RESET;
        end
        else if (cfg_write)
        begin
            radius_cfg_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (int'(radius_cfg_reg) > MAX_RADIUS)
        begin
            radius_sat = RAD_W'(MAX_RADIUS);
        end
        else
        begin
            radius_sat = RAD_W'(radius_cfg_reg);
        end
    end

    // window store
    bbla_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (tail_next),
        .rdata (ram_rdata)
    );

    assign tail_sample = $signed(ram_rdata);

    // window of the next result: owed samples plus the clipped left side
    assign win_count  = CNT_W'(owed_reg) + CNT_W'(left_reg);
    assign drop       = fill_reg > win_count;
    assign sum_out    = drop ? (sum_reg - SUM_W'(tail_sample)) : sum_reg;
    assign flush_more = last_reg && (owed_reg != OWD_W'(1));

    // request payload
    assign q_sum   = sum_out;
    assign q_count = win_count;
    assign q_done  = last_reg && (owed_reg == OWD_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FRONT_IDLE:
            begin
                if (push)
                begin
                    state_next = FRONT_ADD;
                end
            end
            FRONT_ADD:
            begin
                if (last_reg || (int'(owed_reg) + 1 > int'(line_radius_reg)))
                begin
                    state_next = FRONT_EMIT;
                end
                else
                begin
                    state_next = FRONT_IDLE;
                end
            end
            FRONT_EMIT:
            begin
                if (!q_full && !flush_more)
                begin
                    state_next = FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        full   = 1'b1;
        accept = 1'b0;
        ram_we = 1'b0;
        ram_re = 1'b0;
        q_push = 1'b0;
        unique case (state_reg)
            FRONT_IDLE:
            begin
                full   = 1'b0;
                accept = push;
                ram_re = push;
            end
            FRONT_ADD:
            begin
                ram_we = 1'b1;
            end
            FRONT_EMIT:
            begin
                q_push = !q_full;
                ram_re = !q_full && flush_more;
            end
            default:
            begin
                full = 1'b1;
            end
        endcase
    end

    // datapath updates
    always_comb
    begin
        line_radius_next = line_radius_reg;
        in_line_next     = in_line_reg;
        sample_next      = sample_reg;
        last_next        = last_reg;
        wr_ptr_next      = wr_ptr_reg;
        tail_next        = tail_reg;
        sum_next         = sum_reg;
        fill_next        = fill_reg;
        owed_next        = owed_reg;
        left_next        = left_reg;

        // latch the sample; a new line starts with an empty window
        if (accept)
        begin
            sample_next = sample_value;
            last_next   = line_end;
            if (!in_line_reg)
            begin
                line_radius_next = radius_sat;
                tail_next        = wr_ptr_reg;
                sum_next         = '0;
                fill_next        = '0;
                owed_next        = '0;
                left_next        = '0;
            end
        end

        // store the sample and grow the window
        if (state_reg == FRONT_ADD)
        begin
            in_line_next = 1'b1;
            wr_ptr_next  = ptr_inc(wr_ptr_reg);
            sum_next     = sum_reg + SUM_W'(sample_reg);
            fill_next    = fill_reg + 1'b1;
            owed_next    = owed_reg + 1'b1;
        end

        // one result sent: drop the oldest sample if the window shrinks
        if (q_push)
        begin
            sum_next  = sum_out;
            owed_next = owed_reg - 1'b1;
            if (drop)
            begin
                fill_next = fill_reg - 1'b1;
                tail_next = ptr_inc(tail_reg);
            end
            if (left_reg < line_radius_reg)
            begin
                left_next = left_reg + 1'b1;
            end
            if (q_done)
            begin
                in_line_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FRONT_IDLE;
            in_line_reg <= 1'b0;
            wr_ptr_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            in_line_reg <= in_line_next;
            wr_ptr_reg  <= wr_ptr_next;
        end
    end

    // payload registers, latched with each sample, and window registers, set up when a line starts
    always_ff @(posedge clk)
    begin
        line_radius_reg <= line_radius_next;
        sample_reg      <= sample_next;
        last_reg        <= last_next;
        tail_reg        <= tail_next;
        sum_reg         <= sum_next;
        fill_reg        <= fill_next;
        owed_reg        <= owed_next;
        left_reg        <= left_next;
    end

endmodule

// ===== hdl/bbla_fifo.sv =====
// ----------------------------------------------------------------------------
// bbla_fifo
// Short request queue between the front sequencer and the divider.
// ----------------------------------------------------------------------------
module bbla_fifo #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_rd;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (cnt_reg == (PTR_W + 1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = slot_reg[rp_reg];

    // pointers and fill count
    always_comb
    begin
        wp_next  = do_wr ? ptr_inc(wp_reg) : wp_reg;
        rp_next  = do_rd ? ptr_inc(rp_reg) : rp_reg;
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/bbla_divider.sv =====
// ----------------------------------------------------------------------------
// bbla_divider
// Back end: signed window sum over sample count, truncated toward zero, one
// quotient bit per cycle, with an output register toward the result side.
// ----------------------------------------------------------------------------
module bbla_divider import bbla_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 21,
    parameter int CNT_W       = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic signed [SUM_W-1:0]       q_sum,
    input  logic [CNT_W-1:0]              q_count,
    input  logic                          q_done,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [SAMPLE_BITS-1:0] averaged_value,
    output logic                          line_done
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    div_state_t state_reg, state_next;

    logic [STEP_W-1:0]             step_reg, step_next;
    logic [SUM_W-1:0]              quo_reg, quo_next;
    logic [CNT_W-1:0]              rem_reg, rem_next;
    logic [CNT_W-1:0]              div_reg, div_next;
    logic                          neg_reg, neg_next;
    logic                          done_reg, done_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_value_reg;
    logic                          out_done_reg;

    logic                          load_out;
    logic [CNT_W:0]                rem_shift;
    logic [SUM_W-1:0]              sum_abs;
    logic [SUM_W-1:0]              quo_signed;

    assign sum_abs    = q_sum[SUM_W-1] ? (~q_sum + 1'b1) : q_sum;
    assign rem_shift  = {rem_reg, quo_reg[SUM_W-1]};
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (step_reg == STEP_W'(1))
                begin
                    state_next = DIV_HOLD;
                end
            end
            DIV_HOLD:
            begin
                if (!out_valid_reg || pop)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            DIV_IDLE:
            begin
                q_pop = !q_empty;
            end
            DIV_RUN:
            begin
                q_pop = 1'b0;
            end
            DIV_HOLD:
            begin
                load_out = !out_valid_reg || pop;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // restoring division on the magnitude
    always_comb
    begin
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        done_next = done_reg;
        if (q_pop)
        begin
            step_next = STEP_W'(SUM_W);
            quo_next  = sum_abs;
            rem_next  = '0;
            div_next  = q_count;
            neg_next  = q_sum[SUM_W-1];
            done_next = q_done;
        end
        else if (state_reg == DIV_RUN)
        begin
            step_next = step_reg - 1'b1;
            if (rem_shift >= {1'b0, div_reg})
            begin
                rem_next = CNT_W'(rem_shift - {1'b0, div_reg});
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    // result register valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= DIV_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        neg_reg  <= neg_next;
        done_reg <= done_next;
        if (load_out)
        begin
            out_value_reg <= $signed(quo_signed[SAMPLE_BITS-1:0]);
            out_done_reg  <= done_reg;
        end
    end

    assign empty          = !out_valid_reg;
    assign averaged_value = out_value_reg;
    assign line_done      = out_done_reg;

endmodule

// ===== hdl/box_blur_line_average.sv =====
// ----------------------------------------------------------------------------
// box_blur_line_average
// One pass of a box blur along a line of signed samples, edges clipped.
// ----------------------------------------------------------------------------
// Each result is the mean of the samples within the radius around one sample
// of the line, over the samples actually present, truncated toward zero. The
// radius is latched on the first sample of a line. Result k of a line leaves
// once sample k + radius has arrived; the sample flagged line_end flushes all
// remaining results, the last one flagged line_done. The front takes a sample,
// adds it to the window and, if it yields a result, sends its request (on the
// line_end sample, one per remaining result), taking no new sample meanwhile;
// it stalls when the 4-entry request queue is full. Each result then goes
// through a one-bit-per-cycle divider of SAMPLE_BITS + clog2(2*MAX_RADIUS + 2)
// steps (21 at the defaults); taking a new request only after loading its
// last result into the output register, the divider sets the sustained rate. The
// window store needs no clearing after reset: only current-line samples are read.
module box_blur_line_average import bbla_pkg::*; #(
    parameter int MAX_RADIUS  = 15,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] sample_value,
    input  logic                          line_end,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [SAMPLE_BITS-1:0] averaged_value,
    output logic                          line_done
);

    localparam int DEPTH   = 2 * MAX_RADIUS + 1;
    localparam int CNT_W   = $clog2(DEPTH + 2);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(DEPTH + 1);
    localparam int ENTRY_W = SUM_W + CNT_W + 1;

    logic                    fq_push;
    logic                    fq_full;
    logic signed [SUM_W-1:0] fq_sum;
    logic [CNT_W-1:0]        fq_count;
    logic                    fq_done;
    logic                    bq_pop;
    logic                    bq_empty;
    logic [ENTRY_W-1:0]      bq_entry;

    // sample intake, window store and running sum
    bbla_front #(
        .MAX_RADIUS  (MAX_RADIUS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .sample_value (sample_value),
        .line_end     (line_end),
        .q_full       (fq_full),
        .q_push       (fq_push),
        .q_sum        (fq_sum),
        .q_count      (fq_count),
        .q_done       (fq_done)
    );

    // request queue
    bbla_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (4)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (fq_push),
        .wdata ({fq_done, fq_count, fq_sum}),
        .full  (fq_full),
        .rd    (bq_pop),
        .rdata (bq_entry),
        .empty (bq_empty)
    );

    // division and result register
    bbla_divider #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W)
    ) u_divider (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (bq_empty),
        .q_pop          (bq_pop),
        .q_sum          ($signed(bq_entry[SUM_W-1:0])),
        .q_count        (bq_entry[SUM_W +: CNT_W]),
        .q_done         (bq_entry[ENTRY_W-1]),
        .empty          (empty),
        .pop            (pop),
        .averaged_value (averaged_value),
        .line_done      (line_done)
    );

endmodule
